/* rtl/core/csof_pkg.sv */
// Shared types, register indexes, codes and reset values of the candle spike filter.
// Holds the bar price check used on the raw and on the corrected bar.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csof_pkg;

  localparam int PriceBitsDef = 32;
  localparam int WindowMaxDef = 128;
  localparam int StatsCap     = 100;
  localparam int MinHistory   = 8;
  localparam int VolW         = 40;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 32;
  localparam int NumFlags     = 10;
  localparam int BarW         = 64;

  localparam logic [CfgIdxW-1:0] REG_SHADOW_RATIO = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MIN_BODY     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAD_MULT     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DEV_LIMIT    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GAP_MULT     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_VOL_MULT     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_FLASH_CHANGE = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_CONTROL      = 3'd7;

  localparam logic [15:0] RstShadowRatio = 16'd768;
  localparam logic [31:0] RstMinBody     = 32'd1;
  localparam logic [15:0] RstMadMult     = 16'd1280;
  localparam logic [15:0] RstDevLimit    = 16'd3277;
  localparam logic [15:0] RstGapMult     = 16'd1280;
  localparam logic [15:0] RstVolMult     = 16'd2560;
  localparam logic [15:0] RstFlashChange = 16'd1311;
  localparam logic [30:0] RstControl     = 31'd335662463;

  localparam logic [1:0] POL_PASS   = 2'd0;
  localparam logic [1:0] POL_MARK   = 2'd1;
  localparam logic [1:0] POL_TRUNC  = 2'd2;
  localparam logic [1:0] POL_REJECT = 2'd3;

  localparam logic [2:0] VER_PASS      = 3'd0;
  localparam logic [2:0] VER_MARKED    = 3'd1;
  localparam logic [2:0] VER_TRUNC     = 3'd2;
  localparam logic [2:0] VER_REJECT    = 3'd3;
  localparam logic [2:0] VER_INV_INPUT = 3'd4;
  localparam logic [2:0] VER_INV_FIX   = 3'd5;

  localparam int FL_UPPER  = 0;
  localparam int FL_LOWER  = 1;
  localparam int FL_CRASH  = 2;
  localparam int FL_SPIKE  = 3;
  localparam int FL_DATA   = 4;
  localparam int FL_GAP    = 5;
  localparam int FL_VOLUME = 6;
  localparam int FL_ZEROV  = 7;
  localparam int FL_MAD    = 8;
  localparam int FL_ABS    = 9;

  localparam int EN_SHADOW = 0;
  localparam int EN_FLASH  = 1;
  localparam int EN_DATA   = 2;
  localparam int EN_GAP    = 3;
  localparam int EN_MAD    = 4;
  localparam int EN_ABS    = 5;
  localparam int EN_VOLUME = 6;
  localparam int CTL_DRY   = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PREV,
    ST_SUM,
    ST_MSEL,
    ST_MFIX,
    ST_DSEL,
    ST_DFIX,
    ST_EVAL,
    ST_DECIDE,
    ST_CLAMP,
    ST_COMMIT
  } state_e;

  function automatic logic bar_ok(input logic signed [BarW-1:0] o, input logic signed [BarW-1:0] h,
                                  input logic signed [BarW-1:0] l, input logic signed [BarW-1:0] c);
    bar_ok = (o > 0) && (h > 0) && (l > 0) && (c > 0) && (h >= l) &&
             (o <= h) && (o >= l) && (c <= h) && (c >= l);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/candle_spike_outlier_filter.sv */
// An invalid bar goes from the check straight to the commit; before the history is
// filled the window passes are skipped; else the n kept bars are read in passes, one
// window entry per cycle from the history memory, for the sums, each bit of the median
// and MAD rank selections and their fix-up steps. One item at a time; the next is taken
// once the result is in the output register. Reset returns the configuration registers to
// their defaults and empties the history; the memory itself is not cleared. Depends on csof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module candle_spike_outlier_filter import csof_pkg::*; #(
  parameter int WINDOW_MAX = WindowMaxDef,
  parameter int PRICE_BITS = PriceBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [PRICE_BITS-1:0]      open_price_i,
  input  logic [PRICE_BITS-1:0]      high_price_i,
  input  logic [PRICE_BITS-1:0]      low_price_i,
  input  logic [PRICE_BITS-1:0]      close_price_i,
  input  logic signed [VolW-1:0]     bar_volume_i,
  input  logic                       time_ok_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [PRICE_BITS-1:0]      out_open_o,
  output logic [PRICE_BITS-1:0]      out_high_o,
  output logic [PRICE_BITS-1:0]      out_low_o,
  output logic [PRICE_BITS-1:0]      out_close_o,
  output logic [NumFlags-1:0]        anomaly_flags_o,
  output logic [1:0]                 chosen_policy_o,
  output logic                       accepted_o,
  output logic                       modified_o,
  output logic [2:0]                 verdict_o
);

  localparam int PW     = PRICE_BITS;
  localparam int AW     = $clog2(WINDOW_MAX);
  localparam int CW     = $clog2(WINDOW_MAX + 1);
  localparam int VW     = PW + 1;
  localparam int BW     = $clog2(VW);
  localparam int MEMW   = 2 * PW + VolW;
  localparam int EBW    = (PW > 32) ? PW : 32;
  localparam int TW     = EBW + 16;
  localparam int SW     = EBW + 10;
  localparam int RW     = PW + CW;
  localparam int VSW    = VolW + CW;
  localparam int DW     = PW + 9;
  localparam int WinCap = (StatsCap < WINDOW_MAX) ? StatsCap : WINDOW_MAX;

  state_e st_q, st_d;

  logic [15:0] ratio_q, madm_q, devl_q, gapm_q, volm_q, flash_q;
  logic [31:0] minb_q;
  logic [30:0] ctrl_q;

  logic [AW-1:0] wp_q;
  logic [CW-1:0] fill_q;

  logic [MEMW-1:0] mem_q [WINDOW_MAX];
  logic [MEMW-1:0] rdata_q;
  logic [MEMW-1:0] wdata;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;

  logic [PW-1:0]   o_q, h_q, l_q, c_q;
  logic [VolW-1:0] v_q;
  logic            tok_q, inv_q, hist_q;

  logic [CW-1:0] n_q, k0_q, cnt_q, kr_q, c0_q, cle_q;
  logic [AW-1:0] addr_q, start_q;
  logic [PW-1:0] prev_q;
  logic [RW-1:0] rsum_q;
  logic [VSW-1:0] vsum_q;
  logic [VW-1:0] pfx_q, msk_q, mgt_q, m2_q, dev2_q;
  logic [VW:0]   mad4_q;
  logic [BW-1:0] bit_q;

  logic [TW-1:0]      thr_q;
  logic [PW+15:0]     flim_q;
  logic [RW-1:0]      gl_q;
  logic [RW+15:0]     gr_q;
  logic [VW+16:0]     madr_q;
  logic [VW+15:0]     devr_q;
  logic [VSW-1:0]     vl_q;
  logic [VSW+15:0]    vr_q;

  logic [NumFlags-1:0] fl_q;
  logic [1:0]          pol_q;
  logic signed [SW-1:0] nh_q, nl_q, no_q, nc_q;

  logic out_valid_q;

  logic accept, fire, in_ok;
  logic [6:0]    wraw;
  logic [CW-1:0] win, need, n_cur;
  logic [CW:0]   wpx, nx, start_x, fill_inc;
  logic [AW-1:0] start_c, prev_addr, addr_inc;

  logic [PW-1:0]   e_close, e_range;
  logic [VolW-1:0] e_vol;
  logic [VW-1:0]   c2, sel_v, bval, mgt_tot;
  logic [VW:0]     fix_res;
  logic            issue, take, last, match, le, gt;
  logic [CW-1:0]   c0_tot, cle_tot;

  logic [PW-1:0]  top, bot, body, gdiff, rng;
  logic [EBW-1:0] eb;
  logic [VW-1:0]  dev2_c;
  logic [PW-1:0]  px [4];
  logic [NumFlags-1:0] fl_c;
  logic [1:0]     pol_c;
  logic [TW:0]    tsum;
  logic [TW-8:0]  t_c;
  logic           hh, ll;
  logic signed [SW-1:0] hs, ls;

  logic            fix_ok, res_acc, res_mod;
  logic [PW-1:0]   r_open, r_high, r_low, r_close;
  logic [NumFlags-1:0] r_flags;
  logic [1:0]      r_pol;
  logic [2:0]      r_ver;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RstShadowRatio;
      minb_q  <= RstMinBody;
      madm_q  <= RstMadMult;
      devl_q  <= RstDevLimit;
      gapm_q  <= RstGapMult;
      volm_q  <= RstVolMult;
      flash_q <= RstFlashChange;
      ctrl_q  <= RstControl;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SHADOW_RATIO: ratio_q <= cfg_data_i[15:0];
        REG_MIN_BODY:     minb_q  <= cfg_data_i[31:0];
        REG_MAD_MULT:     madm_q  <= cfg_data_i[15:0];
        REG_DEV_LIMIT:    devl_q  <= cfg_data_i[15:0];
        REG_GAP_MULT:     gapm_q  <= cfg_data_i[15:0];
        REG_VOL_MULT:     volm_q  <= cfg_data_i[15:0];
        REG_FLASH_CHANGE: flash_q <= cfg_data_i[15:0];
        REG_CONTROL:      ctrl_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // window sizing and ring addressing
  always_comb begin
    wraw = ctrl_q[30:24];
    if (wraw == '0) begin
      win = CW'(1);
    end else if (int'(wraw) > WinCap) begin
      win = CW'(WinCap);
    end else begin
      win = CW'(wraw);
    end
    need     = (win < CW'(MinHistory)) ? win : CW'(MinHistory);
    n_cur    = (fill_q < win) ? fill_q : win;
    wpx      = (CW+1)'(wp_q);
    nx       = (CW+1)'(n_cur);
    start_x  = (wpx >= nx) ? (wpx - nx) : (wpx + (CW+1)'(WINDOW_MAX) - nx);
    start_c  = start_x[AW-1:0];
    prev_addr = (wp_q == '0) ? AW'(WINDOW_MAX - 1) : (wp_q - 1'b1);
    addr_inc = (addr_q == AW'(WINDOW_MAX - 1)) ? '0 : (addr_q + 1'b1);
    fill_inc = (CW+1)'(fill_q) + (CW+1)'(1);
  end

  assign in_ok = bar_ok(BarW'(o_q), BarW'(h_q), BarW'(l_q), BarW'(c_q)) &&
                 !v_q[VolW-1] && tok_q;

  // pass over the window: issue one read per cycle, consume each in the cycle after
  always_comb begin
    e_close = rdata_q[MEMW-1 -: PW];
    e_range = rdata_q[VolW +: PW];
    e_vol   = rdata_q[VolW-1:0];
    c2      = {e_close, 1'b0};
    if (st_q == ST_DSEL || st_q == ST_DFIX) begin
      sel_v = (c2 > m2_q) ? (c2 - m2_q) : (m2_q - c2);
    end else begin
      sel_v = {1'b0, e_close};
    end
    issue   = cnt_q < n_q;
    take    = cnt_q != '0;
    last    = cnt_q == n_q;
    match   = take && (((sel_v ^ pfx_q) & msk_q) == '0) && !sel_v[bit_q];
    c0_tot  = c0_q + CW'(match);
    le      = take && (sel_v <= pfx_q);
    gt      = take && (sel_v > pfx_q);
    cle_tot = cle_q + CW'(le);
    mgt_tot = (gt && (sel_v < mgt_q)) ? sel_v : mgt_q;
    bval    = ((CW+1)'(cle_tot) >= ((CW+1)'(k0_q) + (CW+1)'(2))) ? pfx_q : mgt_tot;
    fix_res = n_q[0] ? {pfx_q, 1'b0} : ({1'b0, pfx_q} + {1'b0, bval});
  end

  // bar shape terms
  always_comb begin
    top    = (o_q > c_q) ? o_q : c_q;
    bot    = (o_q < c_q) ? o_q : c_q;
    body   = top - bot;
    eb     = (EBW'(body) > EBW'(minb_q)) ? EBW'(body) : EBW'(minb_q);
    gdiff  = (o_q > prev_q) ? (o_q - prev_q) : (prev_q - o_q);
    dev2_c = ({c_q, 1'b0} > m2_q) ? ({c_q, 1'b0} - m2_q) : (m2_q - {c_q, 1'b0});
    rng    = h_q - l_q;
    px[0]  = o_q;
    px[1]  = h_q;
    px[2]  = l_q;
    px[3]  = c_q;
  end

  // anomaly flags and policy
  always_comb begin
    fl_c = '0;
    fl_c[FL_ZEROV] = (v_q == '0);
    if (hist_q) begin
      if (ctrl_q[EN_SHADOW]) begin
        fl_c[FL_UPPER] = TW'({h_q - top, 8'b0}) > thr_q;
        fl_c[FL_LOWER] = TW'({bot - l_q, 8'b0}) > thr_q;
      end
      if (ctrl_q[EN_FLASH] && prev_q != '0) begin
        fl_c[FL_CRASH] = (c_q < prev_q) && ({prev_q - c_q, 16'b0} > flim_q) && (rng != '0) &&
                         ((PW+4)'(c_q - l_q) * (PW+4)'(10) > (PW+4)'(rng) * (PW+4)'(7));
        fl_c[FL_SPIKE] = (c_q > prev_q) && ({c_q - prev_q, 16'b0} > flim_q) && (rng != '0) &&
                         ((PW+4)'(h_q - c_q) * (PW+4)'(10) > (PW+4)'(rng) * (PW+4)'(7));
      end
      if (ctrl_q[EN_DATA]) begin
        for (int k = 0; k < 4; k++) begin
          if ((DW'({px[k], 1'b0}) > DW'(m2_q) * DW'(100)) ||
              (DW'(px[k]) * DW'(200) < DW'(m2_q))) begin
            fl_c[FL_DATA] = 1'b1;
          end
        end
      end
      fl_c[FL_GAP] = ctrl_q[EN_GAP] && (rsum_q != '0) &&
                     ((RW+16)'({gl_q, 8'b0}) > gr_q);
      fl_c[FL_MAD] = ctrl_q[EN_MAD] && (mad4_q != '0) &&
                     ((VW+17)'({dev2_q, 9'b0}) > madr_q);
      fl_c[FL_ABS] = ctrl_q[EN_ABS] && ({dev2_q, 16'b0} > devr_q);
      fl_c[FL_VOLUME] = ctrl_q[EN_VOLUME] && (vsum_q != '0) &&
                        ((VSW+16)'({vl_q, 8'b0}) > vr_q);
    end
    if (fl_c == '0) begin
      pol_c = POL_PASS;
    end else if ((fl_c & ctrl_q[21:12]) != '0) begin
      pol_c = ctrl_q[11:10];
    end else begin
      pol_c = ctrl_q[9:8];
    end
    if (ctrl_q[CTL_DRY]) begin
      pol_c = POL_MARK;
    end
    tsum = (TW+1)'(thr_q) + (TW+1)'(128);
    t_c  = tsum[TW:8];
    hh   = (TW+1)'({h_q, 8'b0}) > ((TW+1)'({top, 8'b0}) + (TW+1)'(thr_q));
    ll   = ((TW+1)'({l_q, 8'b0}) + (TW+1)'(thr_q)) < (TW+1)'({bot, 8'b0});
    hs   = (nh_q < nl_q) ? nl_q : nh_q;
    ls   = (nh_q < nl_q) ? nh_q : nl_q;
  end

  // final result of the item
  always_comb begin
    fix_ok  = bar_ok(BarW'(no_q), BarW'(nh_q), BarW'(nl_q), BarW'(nc_q));
    r_open  = o_q;
    r_high  = h_q;
    r_low   = l_q;
    r_close = c_q;
    r_flags = fl_q;
    r_pol   = pol_q;
    res_acc = 1'b1;
    res_mod = 1'b0;
    r_ver   = VER_PASS;
    if (inv_q) begin
      r_flags = '0;
      r_flags[FL_DATA] = 1'b1;
      r_pol   = POL_REJECT;
      res_acc = 1'b0;
      r_ver   = VER_INV_INPUT;
    end else begin
      case (pol_q)
        POL_PASS:   r_ver = VER_PASS;
        POL_MARK:   r_ver = VER_MARKED;
        POL_REJECT: begin
          r_ver   = VER_REJECT;
          res_acc = 1'b0;
        end
        POL_TRUNC: begin
          res_mod = 1'b1;
          if (fix_ok) begin
            r_open  = no_q[PW-1:0];
            r_high  = nh_q[PW-1:0];
            r_low   = nl_q[PW-1:0];
            r_close = nc_q[PW-1:0];
            r_ver   = VER_TRUNC;
          end else begin
            r_pol   = POL_REJECT;
            res_acc = 1'b0;
            r_ver   = VER_INV_FIX;
          end
        end
        default: r_ver = VER_PASS;
      endcase
    end
    wdata = {r_close, r_high - r_low, v_q};
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:   if (accept) st_d = ST_CHECK;
      ST_CHECK: begin
        if (!in_ok) begin
          st_d = ST_COMMIT;
        end else if (fill_q >= need) begin
          st_d = ST_PREV;
        end else begin
          st_d = ST_EVAL;
        end
      end
      ST_PREV:   st_d = ST_SUM;
      ST_SUM:    if (last) st_d = ST_MSEL;
      ST_MSEL:   if (last && bit_q == '0) st_d = ST_MFIX;
      ST_MFIX:   if (last) st_d = ST_DSEL;
      ST_DSEL:   if (last && bit_q == '0) st_d = ST_DFIX;
      ST_DFIX:   if (last) st_d = ST_EVAL;
      ST_EVAL:   st_d = ST_DECIDE;
      ST_DECIDE: st_d = ST_CLAMP;
      ST_CLAMP:  st_d = ST_COMMIT;
      ST_COMMIT: if (fire) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    rd_addr    = addr_q;
    fire       = 1'b0;
    case (st_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_CHECK:  rd_addr = prev_addr;
      ST_COMMIT: fire = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  assign mem_we = fire && res_acc;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= wdata;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (mem_we) begin
        wp_q   <= (wp_q == AW'(WINDOW_MAX - 1)) ? '0 : (wp_q + 1'b1);
        fill_q <= (fill_inc > (CW+1)'(win)) ? win : fill_inc[CW-1:0];
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          o_q   <= open_price_i;
          h_q   <= high_price_i;
          l_q   <= low_price_i;
          c_q   <= close_price_i;
          v_q   <= bar_volume_i;
          tok_q <= time_ok_i;
        end
      end
      ST_CHECK: begin
        inv_q   <= !in_ok;
        hist_q  <= fill_q >= need;
        n_q     <= n_cur;
        k0_q    <= CW'((n_cur - 1'b1) >> 1);
        addr_q  <= start_c;
        start_q <= start_c;
        cnt_q   <= '0;
        rsum_q  <= '0;
        vsum_q  <= '0;
        prev_q  <= '0;
        m2_q    <= '0;
        mad4_q  <= '0;
      end
      ST_PREV: prev_q <= e_close;
      ST_SUM, ST_MSEL, ST_MFIX, ST_DSEL, ST_DFIX: begin
        if (issue) begin
          addr_q <= addr_inc;
        end
        if (last) begin
          cnt_q  <= '0;
          addr_q <= start_q;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (st_q == ST_SUM && take) begin
          rsum_q <= rsum_q + RW'(e_range);
          vsum_q <= vsum_q + VSW'(e_vol);
        end
        if (st_q == ST_MSEL || st_q == ST_DSEL) begin
          if (last) begin
            c0_q  <= '0;
            msk_q <= (msk_q >> 1) | {1'b1, {(VW-1){1'b0}}};
            bit_q <= bit_q - 1'b1;
            if (kr_q >= c0_tot) begin
              pfx_q <= pfx_q | (VW'(1) << bit_q);
              kr_q  <= kr_q - c0_tot;
            end
            if (bit_q == '0) begin
              cle_q <= '0;
              mgt_q <= '1;
            end
          end else begin
            c0_q <= c0_tot;
          end
        end
        if (st_q == ST_MFIX || st_q == ST_DFIX) begin
          cle_q <= cle_tot;
          mgt_q <= mgt_tot;
        end
        if (last && (st_q == ST_SUM || st_q == ST_MFIX)) begin
          pfx_q <= '0;
          msk_q <= '0;
          bit_q <= BW'(VW - 1);
          kr_q  <= k0_q;
          c0_q  <= '0;
        end
        if (last && st_q == ST_MFIX) begin
          m2_q <= fix_res[VW-1:0];
        end
        if (last && st_q == ST_DFIX) begin
          mad4_q <= fix_res;
        end
      end
      ST_EVAL: begin
        thr_q  <= TW'(eb) * TW'(ratio_q);
        flim_q <= (PW+16)'(prev_q) * (PW+16)'(flash_q);
        gl_q   <= RW'(gdiff) * RW'(n_q);
        gr_q   <= (RW+16)'(rsum_q) * (RW+16)'(gapm_q);
        madr_q <= (VW+17)'(mad4_q) * (VW+17)'(madm_q);
        devr_q <= (VW+16)'(m2_q) * (VW+16)'(devl_q);
        vl_q   <= VSW'(v_q) * VSW'(n_q);
        vr_q   <= (VSW+16)'(vsum_q) * (VSW+16)'(volm_q);
        dev2_q <= dev2_c;
      end
      ST_DECIDE: begin
        fl_q  <= fl_c;
        pol_q <= pol_c;
        nh_q  <= (fl_c[FL_UPPER] && hh) ? (SW'(top) + SW'(t_c)) : SW'(h_q);
        nl_q  <= (fl_c[FL_LOWER] && ll) ? (SW'(bot) - SW'(t_c)) : SW'(l_q);
        no_q  <= (fl_c[FL_GAP] && fill_q != '0) ? SW'(prev_q) : SW'(o_q);
        nc_q  <= SW'(c_q);
      end
      ST_CLAMP: begin
        nh_q <= hs;
        nl_q <= ls;
        no_q <= (no_q > hs) ? hs : ((no_q < ls) ? ls : no_q);
        nc_q <= (nc_q > hs) ? hs : ((nc_q < ls) ? ls : nc_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_open_o      <= r_open;
      out_high_o      <= r_high;
      out_low_o       <= r_low;
      out_close_o     <= r_close;
      anomaly_flags_o <= r_flags;
      chosen_policy_o <= r_pol;
      accepted_o      <= res_acc;
      modified_o      <= res_mod;
      verdict_o       <= r_ver;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> st_q == ST_CHECK)
    else $error("accepted item did not start the check");

  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MSEL || st_q == ST_DSEL) |-> kr_q < n_q)
    else $error("rank left the candidate set");

  a_sel_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MSEL && st_d == ST_MFIX) |-> bit_q == '0)
    else $error("median selection ended early");

  a_push_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> fill_q != '0)
    else $error("history push left the window empty");

endmodule

`default_nettype wire
